### hdl/rti_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package rti_pkg;

  localparam int COORD_BITS = 20;
  localparam int DIST_BITS  = 32;
  localparam int FRAC       = 10;
  localparam int FB         = 16;
  localparam int THR_W      = 20;
  localparam int EW         = COORD_BITS + 1;
  localparam int MW         = 2 * EW;
  localparam int PW         = MW + 1;
  localparam int XW         = PW - FRAC;
  localparam int DW         = EW + XW;
  localparam int SW         = DW + 2;
  localparam int QW         = DIST_BITS - 1;
  localparam int SAT_SHIFT  = QW - FB;
  localparam int RW         = SW + QW;
  localparam int VW         = 3 * COORD_BITS;
  localparam int CFG_IDX_W  = 3;

  localparam logic [CFG_IDX_W-1:0] REG_VERTEX_A  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_VERTEX_B  = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_VERTEX_C  = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_CULL      = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = CFG_IDX_W'(4);

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [EW-1:0]         edge_t;
  typedef logic signed [MW-1:0]         mult_t;
  typedef logic signed [XW-1:0]         xw_t;
  typedef logic signed [DW-1:0]         dprod_t;
  typedef logic signed [SW-1:0]         sum_t;

  typedef struct packed {
    edge_t x;
    edge_t y;
    edge_t z;
  } vec_t;

  typedef struct packed {
    xw_t x;
    xw_t y;
    xw_t z;
  } xvec_t;

  typedef struct packed {
    coord_t ox;
    coord_t oy;
    coord_t oz;
    coord_t dx;
    coord_t dy;
    coord_t dz;
  } ray_t;

  typedef struct packed {
    sum_t det;
    sum_t un;
    sum_t vn;
    sum_t tn;
  } dots_t;

  typedef struct packed {
    logic          hit;
    logic          neg;
    logic          sat;
    logic [SW-1:0] mag;
    logic [SW-1:0] den;
  } divreq_t;

  typedef struct packed {
    logic          hit;
    logic          neg;
    logic          sat;
    logic [SW-1:0] den;
    logic [RW-1:0] rem;
    logic [QW-1:0] q;
  } divst_t;

  function automatic vec_t unpack_vtx(logic [VW-1:0] p);
    vec_t r;
    r.x = EW'($signed(p[COORD_BITS-1:0]));
    r.y = EW'($signed(p[2*COORD_BITS-1:COORD_BITS]));
    r.z = EW'($signed(p[3*COORD_BITS-1:2*COORD_BITS]));
    return r;
  endfunction

endpackage
`default_nettype wire

### hdl/rti_ray_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface rti_ray_if;
  logic                 valid;
  logic                 ready;
  rti_pkg::coord_t      origin_x;
  rti_pkg::coord_t      origin_y;
  rti_pkg::coord_t      origin_z;
  rti_pkg::coord_t      direction_x;
  rti_pkg::coord_t      direction_y;
  rti_pkg::coord_t      direction_z;

  modport source(output valid, origin_x, origin_y, origin_z, direction_x, direction_y,
                 direction_z, input ready);
  modport sink(input valid, origin_x, origin_y, origin_z, direction_x, direction_y,
               direction_z, output ready);
endinterface
`default_nettype wire

### hdl/rti_hit_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface rti_hit_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 hit;
  logic signed [rti_pkg::DIST_BITS-1:0] distance;

  modport source(output valid, hit, distance, input ready);
  modport sink(input valid, hit, distance, output ready);
endinterface
`default_nettype wire

### hdl/rti_geom.sv
`timescale 1ns / 1ps
`default_nettype none
module rti_geom (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic [rti_pkg::VW-1:0]   vertex_a,
  input  wire logic [rti_pkg::VW-1:0]   vertex_b,
  input  wire logic [rti_pkg::VW-1:0]   vertex_c,
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire rti_pkg::ray_t            in_ray,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output rti_pkg::dots_t                out_dots
);

  function automatic rti_pkg::xw_t cross_fl(rti_pkg::mult_t p, rti_pkg::mult_t q);
    logic signed [rti_pkg::PW-1:0] d;
    d = rti_pkg::PW'(p) - rti_pkg::PW'(q);
    return $signed(d[rti_pkg::PW-1:rti_pkg::FRAC]);
  endfunction

  logic v1_r, v2_r, v3_r, v4_r, v5_r;
  logic en1, en2, en3, en4, en5;

  rti_pkg::vec_t a, b, c;
  rti_pkg::vec_t ab_nxt, ac_nxt, tv_nxt, dir_nxt;
  rti_pkg::vec_t ab1_r, ac1_r, tv1_r, dir1_r;
  rti_pkg::vec_t ab2_r, ac2_r, tv2_r, dir2_r;
  rti_pkg::vec_t ab3_r, ac3_r, tv3_r, dir3_r;
  rti_pkg::mult_t pm_nxt [6];
  rti_pkg::mult_t qm_nxt [6];
  rti_pkg::mult_t pm_r [6];
  rti_pkg::mult_t qm_r [6];
  rti_pkg::xvec_t pv_nxt, qv_nxt, pv_r, qv_r;
  rti_pkg::dprod_t dm_nxt [12];
  rti_pkg::dprod_t dm_r [12];
  rti_pkg::dots_t  dots_nxt, dots_r;

  assign en5 = !v5_r || out_ready;
  assign en4 = !v4_r || en5;
  assign en3 = !v3_r || en4;
  assign en2 = !v2_r || en3;
  assign en1 = !v1_r || en2;
  assign in_ready  = en1;
  assign out_valid = v5_r;
  assign out_dots  = dots_r;

  always_comb begin
    a = rti_pkg::unpack_vtx(vertex_a);
    b = rti_pkg::unpack_vtx(vertex_b);
    c = rti_pkg::unpack_vtx(vertex_c);
    ab_nxt.x  = b.x - a.x;
    ab_nxt.y  = b.y - a.y;
    ab_nxt.z  = b.z - a.z;
    ac_nxt.x  = c.x - a.x;
    ac_nxt.y  = c.y - a.y;
    ac_nxt.z  = c.z - a.z;
    tv_nxt.x  = rti_pkg::EW'(in_ray.ox) - a.x;
    tv_nxt.y  = rti_pkg::EW'(in_ray.oy) - a.y;
    tv_nxt.z  = rti_pkg::EW'(in_ray.oz) - a.z;
    dir_nxt.x = rti_pkg::EW'(in_ray.dx);
    dir_nxt.y = rti_pkg::EW'(in_ray.dy);
    dir_nxt.z = rti_pkg::EW'(in_ray.dz);
  end

  always_comb begin
    pm_nxt[0] = rti_pkg::MW'(dir1_r.y) * rti_pkg::MW'(ac1_r.z);
    pm_nxt[1] = rti_pkg::MW'(dir1_r.z) * rti_pkg::MW'(ac1_r.y);
    pm_nxt[2] = rti_pkg::MW'(dir1_r.z) * rti_pkg::MW'(ac1_r.x);
    pm_nxt[3] = rti_pkg::MW'(dir1_r.x) * rti_pkg::MW'(ac1_r.z);
    pm_nxt[4] = rti_pkg::MW'(dir1_r.x) * rti_pkg::MW'(ac1_r.y);
    pm_nxt[5] = rti_pkg::MW'(dir1_r.y) * rti_pkg::MW'(ac1_r.x);
    qm_nxt[0] = rti_pkg::MW'(tv1_r.y) * rti_pkg::MW'(ab1_r.z);
    qm_nxt[1] = rti_pkg::MW'(tv1_r.z) * rti_pkg::MW'(ab1_r.y);
    qm_nxt[2] = rti_pkg::MW'(tv1_r.z) * rti_pkg::MW'(ab1_r.x);
    qm_nxt[3] = rti_pkg::MW'(tv1_r.x) * rti_pkg::MW'(ab1_r.z);
    qm_nxt[4] = rti_pkg::MW'(tv1_r.x) * rti_pkg::MW'(ab1_r.y);
    qm_nxt[5] = rti_pkg::MW'(tv1_r.y) * rti_pkg::MW'(ab1_r.x);
  end

  always_comb begin
    pv_nxt.x = cross_fl(pm_r[0], pm_r[1]);
    pv_nxt.y = cross_fl(pm_r[2], pm_r[3]);
    pv_nxt.z = cross_fl(pm_r[4], pm_r[5]);
    qv_nxt.x = cross_fl(qm_r[0], qm_r[1]);
    qv_nxt.y = cross_fl(qm_r[2], qm_r[3]);
    qv_nxt.z = cross_fl(qm_r[4], qm_r[5]);
  end

  always_comb begin
    dm_nxt[0]  = rti_pkg::DW'(ab3_r.x) * rti_pkg::DW'(pv_r.x);
    dm_nxt[1]  = rti_pkg::DW'(ab3_r.y) * rti_pkg::DW'(pv_r.y);
    dm_nxt[2]  = rti_pkg::DW'(ab3_r.z) * rti_pkg::DW'(pv_r.z);
    dm_nxt[3]  = rti_pkg::DW'(tv3_r.x) * rti_pkg::DW'(pv_r.x);
    dm_nxt[4]  = rti_pkg::DW'(tv3_r.y) * rti_pkg::DW'(pv_r.y);
    dm_nxt[5]  = rti_pkg::DW'(tv3_r.z) * rti_pkg::DW'(pv_r.z);
    dm_nxt[6]  = rti_pkg::DW'(dir3_r.x) * rti_pkg::DW'(qv_r.x);
    dm_nxt[7]  = rti_pkg::DW'(dir3_r.y) * rti_pkg::DW'(qv_r.y);
    dm_nxt[8]  = rti_pkg::DW'(dir3_r.z) * rti_pkg::DW'(qv_r.z);
    dm_nxt[9]  = rti_pkg::DW'(ac3_r.x) * rti_pkg::DW'(qv_r.x);
    dm_nxt[10] = rti_pkg::DW'(ac3_r.y) * rti_pkg::DW'(qv_r.y);
    dm_nxt[11] = rti_pkg::DW'(ac3_r.z) * rti_pkg::DW'(qv_r.z);
  end

  always_comb begin
    dots_nxt.det = rti_pkg::SW'(dm_r[0]) + rti_pkg::SW'(dm_r[1]) + rti_pkg::SW'(dm_r[2]);
    dots_nxt.un  = rti_pkg::SW'(dm_r[3]) + rti_pkg::SW'(dm_r[4]) + rti_pkg::SW'(dm_r[5]);
    dots_nxt.vn  = rti_pkg::SW'(dm_r[6]) + rti_pkg::SW'(dm_r[7]) + rti_pkg::SW'(dm_r[8]);
    dots_nxt.tn  = rti_pkg::SW'(dm_r[9]) + rti_pkg::SW'(dm_r[10]) + rti_pkg::SW'(dm_r[11]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_valid;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
      if (en4) v4_r <= v3_r;
      if (en5) v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      ab1_r  <= ab_nxt;
      ac1_r  <= ac_nxt;
      tv1_r  <= tv_nxt;
      dir1_r <= dir_nxt;
    end
    if (en2) begin
      pm_r   <= pm_nxt;
      qm_r   <= qm_nxt;
      ab2_r  <= ab1_r;
      ac2_r  <= ac1_r;
      tv2_r  <= tv1_r;
      dir2_r <= dir1_r;
    end
    if (en3) begin
      pv_r   <= pv_nxt;
      qv_r   <= qv_nxt;
      ab3_r  <= ab2_r;
      ac3_r  <= ac2_r;
      tv3_r  <= tv2_r;
      dir3_r <= dir2_r;
    end
    if (en4) dm_r <= dm_nxt;
    if (en5) dots_r <= dots_nxt;
  end

endmodule
`default_nettype wire

### hdl/rti_check.sv
`timescale 1ns / 1ps
`default_nettype none
module rti_check (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      cull_backfaces,
  input  wire logic [rti_pkg::THR_W-1:0] det_threshold,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire rti_pkg::dots_t            in_dots,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output rti_pkg::divreq_t               out_req
);

  logic v1_r, v2_r, en1, en2;
  logic rej_nxt, rej_r;
  rti_pkg::sum_t thr_s;
  rti_pkg::dots_t abs_nxt, abs_r;
  logic [rti_pkg::SW:0] uv_sum;
  rti_pkg::sum_t tn_mag;
  rti_pkg::divreq_t req_nxt, req_r;

  assign en2 = !v2_r || out_ready;
  assign en1 = !v1_r || en2;
  assign in_ready  = en1;
  assign out_valid = v2_r;
  assign out_req   = req_r;

  always_comb begin
    thr_s = $signed({{(rti_pkg::SW - rti_pkg::THR_W){1'b0}}, det_threshold});
    abs_nxt = in_dots;
    if (in_dots.det[rti_pkg::SW-1]) begin
      abs_nxt.det = -in_dots.det;
      abs_nxt.un  = -in_dots.un;
      abs_nxt.vn  = -in_dots.vn;
      abs_nxt.tn  = -in_dots.tn;
    end
    if (cull_backfaces) begin
      rej_nxt = (in_dots.det <= thr_s);
    end else begin
      rej_nxt = (abs_nxt.det <= thr_s);
    end
  end

  always_comb begin
    uv_sum = (rti_pkg::SW+1)'(abs_r.un) + (rti_pkg::SW+1)'(abs_r.vn);
    tn_mag = abs_r.tn[rti_pkg::SW-1] ? -abs_r.tn : abs_r.tn;
    req_nxt.hit = !rej_r && !abs_r.un[rti_pkg::SW-1] && (abs_r.un <= abs_r.det)
                  && !abs_r.vn[rti_pkg::SW-1]
                  && ($signed(uv_sum) <= (rti_pkg::SW+1)'(abs_r.det));
    req_nxt.neg = abs_r.tn[rti_pkg::SW-1];
    req_nxt.mag = tn_mag;
    req_nxt.den = abs_r.det;
    req_nxt.sat = ((rti_pkg::SW+rti_pkg::SAT_SHIFT)'(tn_mag)
                   >= {abs_r.det, {rti_pkg::SAT_SHIFT{1'b0}}});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_valid;
      if (en2) v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      abs_r <= abs_nxt;
      rej_r <= rej_nxt;
    end
    if (en2) req_r <= req_nxt;
  end

endmodule
`default_nettype wire

### hdl/rti_div.sv
`timescale 1ns / 1ps
`default_nettype none
module rti_div (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire rti_pkg::divreq_t                  in_req,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic                                   out_hit,
  output logic signed [rti_pkg::DIST_BITS-1:0]   out_distance
);

  logic v_r [rti_pkg::QW];
  logic en [rti_pkg::QW+1];
  rti_pkg::divst_t st_r [rti_pkg::QW];
  rti_pkg::divst_t st_nxt [rti_pkg::QW];
  logic out_v_r, hit_r;
  logic signed [rti_pkg::DIST_BITS-1:0] dist_nxt, dist_r;
  rti_pkg::divst_t last;

  assign en[rti_pkg::QW] = !out_v_r || out_ready;
  assign in_ready     = en[0];
  assign out_valid    = out_v_r;
  assign out_hit      = hit_r;
  assign out_distance = dist_r;

  for (genvar k = 0; k < rti_pkg::QW; k++) begin : g_stage
    localparam int B = rti_pkg::QW - 1 - k;
    rti_pkg::divst_t cur;
    logic vin;
    logic [rti_pkg::RW-1:0] sh;

    if (k == 0) begin : g_first
      always_comb begin
        cur.hit = in_req.hit;
        cur.neg = in_req.neg;
        cur.sat = in_req.sat;
        cur.den = in_req.den;
        cur.rem = rti_pkg::RW'({in_req.mag, {rti_pkg::FB{1'b0}}});
        cur.q   = '0;
      end
      assign vin = in_valid;
    end else begin : g_rest
      assign cur = st_r[k-1];
      assign vin = v_r[k-1];
    end

    assign en[k] = !v_r[k] || en[k+1];

    always_comb begin
      st_nxt[k] = cur;
      sh = rti_pkg::RW'(cur.den) << B;
      if (cur.rem >= sh) begin
        st_nxt[k].rem  = cur.rem - sh;
        st_nxt[k].q[B] = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en[k]) begin
        v_r[k] <= vin;
      end
    end

    always_ff @(posedge clk) begin
      if (en[k]) st_r[k] <= st_nxt[k];
    end
  end

  always_comb begin
    last = st_r[rti_pkg::QW-1];
    if (!last.hit) begin
      dist_nxt = '0;
    end else if (last.sat) begin
      dist_nxt = last.neg ? {1'b1, {rti_pkg::QW{1'b0}}} : {1'b0, {rti_pkg::QW{1'b1}}};
    end else begin
      dist_nxt = last.neg ? -$signed({1'b0, last.q}) : $signed({1'b0, last.q});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (en[rti_pkg::QW]) begin
      out_v_r <= v_r[rti_pkg::QW-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en[rti_pkg::QW]) begin
      hit_r  <= last.hit;
      dist_r <= dist_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_hit |-> out_distance == '0)
    else $error("miss reported with nonzero distance");
  a_enter: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> v_r[0])
    else $error("accepted item missing from first divider stage");
  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[rti_pkg::QW-1] && en[rti_pkg::QW] |=> out_v_r)
    else $error("divider result lost before output register");
  a_sat_sign: assert property (@(posedge clk) disable iff (!rst_n)
    en[rti_pkg::QW] && v_r[rti_pkg::QW-1] && last.hit && last.sat && !last.neg
    |=> out_distance[rti_pkg::DIST_BITS-1] == 1'b0)
    else $error("positive saturation produced a negative distance");
`endif

endmodule
`default_nettype wire

### hdl/ray_triangle_intersect_top.sv
// Fixed-point ray-triangle intersection. The triangle is loaded through the
// configuration port as three packed Q10.10 vertices, a backface cull enable and
// a determinant threshold, and each input item is a ray origin and direction.
// Every ray yields one result: a hit flag and the ray parameter t in saturated
// signed Q16.16, which is zero on a miss. The block takes one item per cycle when
// the output is not stalled, and each result passes through five stages of edge,
// cross and dot product arithmetic, two stages of rejection and bounds tests,
// and a 31-stage restoring divider that resolves one quotient bit per stage,
// followed by the output register.
`timescale 1ns / 1ps
`default_nettype none
module ray_triangle_intersect_top (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_we,
  input  wire logic [rti_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [rti_pkg::VW-1:0]        cfg_wdata,
  rti_ray_if.sink                            in_ch,
  rti_hit_if.source                          out_ch
);

  logic [rti_pkg::VW-1:0]    vertex_a_r, vertex_b_r, vertex_c_r;
  logic                      cull_r;
  logic [rti_pkg::THR_W-1:0] thr_r;
  rti_pkg::ray_t             ray;
  logic                      g_valid, g_ready, c_valid, c_ready;
  rti_pkg::dots_t            dots;
  rti_pkg::divreq_t          req;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vertex_a_r <= '0;
      vertex_b_r <= '0;
      vertex_c_r <= '0;
      cull_r     <= 1'b0;
      thr_r      <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        rti_pkg::REG_VERTEX_A:  vertex_a_r <= cfg_wdata;
        rti_pkg::REG_VERTEX_B:  vertex_b_r <= cfg_wdata;
        rti_pkg::REG_VERTEX_C:  vertex_c_r <= cfg_wdata;
        rti_pkg::REG_CULL:      cull_r     <= cfg_wdata[0];
        rti_pkg::REG_THRESHOLD: thr_r      <= cfg_wdata[rti_pkg::THR_W-1:0];
        default: ;
      endcase
    end
  end

  assign ray.ox = in_ch.origin_x;
  assign ray.oy = in_ch.origin_y;
  assign ray.oz = in_ch.origin_z;
  assign ray.dx = in_ch.direction_x;
  assign ray.dy = in_ch.direction_y;
  assign ray.dz = in_ch.direction_z;

  rti_geom u_geom (
    .clk       (clk),
    .rst_n     (rst_n),
    .vertex_a  (vertex_a_r),
    .vertex_b  (vertex_b_r),
    .vertex_c  (vertex_c_r),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_ray    (ray),
    .out_valid (g_valid),
    .out_ready (g_ready),
    .out_dots  (dots)
  );

  rti_check u_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .cull_backfaces (cull_r),
    .det_threshold  (thr_r),
    .in_valid       (g_valid),
    .in_ready       (g_ready),
    .in_dots        (dots),
    .out_valid      (c_valid),
    .out_ready      (c_ready),
    .out_req        (req)
  );

  rti_div u_div (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (c_valid),
    .in_ready     (c_ready),
    .in_req       (req),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .out_hit      (out_ch.hit),
    .out_distance (out_ch.distance)
  );

endmodule
`default_nettype wire
